// ----- hw/rtl/mgsb_pkg.sv -----
// ----------------------------------------------------------------------------
// mgsb_pkg
// Shared types and constants of the glyph string blitter: screen limits,
// register indexes, configuration bundle and controller/datapath signals.
// ----------------------------------------------------------------------------
package mgsb_pkg;

	localparam logic [15:0] SCREEN_W = 16'd480;
	localparam logic [15:0] SCREEN_H = 16'd800;

	// bytes per glyph reach 32 * 255, so 13 bits hold the count
	localparam int BIG_W = 13;

	typedef enum logic [2:0] {
		REG_START_X     = 3'd0,
		REG_START_Y     = 3'd1,
		REG_GLYPH_SIZE  = 3'd2,
		REG_GLYPH_COUNT = 3'd3,
		REG_FG_COLOR    = 3'd4,
		REG_BG_COLOR    = 3'd5,
		REG_MODE_FLAGS  = 3'd6,
		REG_BOX_EXTENT  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [7:0]  glyph_size;
		logic [7:0]  glyph_count;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
		logic [1:0]  mode_flags;
		logic [31:0] box_extent;
	} cfg_t;

	// x in the lowest bits, as on the output bus
	typedef struct packed {
		logic [15:0] color;
		logic [15:0] y;
		logic [15:0] x;
	} pixel_t;

	typedef struct packed {
		logic init_mul;
		logic init_set;
		logic load;
		logic set_done;
		logic skip;
		logic wrap;
		logic check;
		logic step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic exhausted;
		logic first;
		logic aborted;
		logic check_fail;
		logic step_ready;
		logic step_end;
		logic in_ready;
	} sts_t;

endpackage

// ----- hw/rtl/mgsb_regs.sv -----
// ----------------------------------------------------------------------------
// mgsb_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module mgsb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output mgsb_pkg::cfg_t     cfg
);

	mgsb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x     <= 16'd0;
			cfg_q.start_y     <= 16'd0;
			cfg_q.glyph_size  <= 8'd8;
			cfg_q.glyph_count <= 8'd0;
			cfg_q.fg_color    <= 16'hFFFF;
			cfg_q.bg_color    <= 16'd0;
			cfg_q.mode_flags  <= 2'd0;
			cfg_q.box_extent  <= 32'd0;
		end else if (cfg_we) begin
			unique case (mgsb_pkg::reg_idx_t'(cfg_index))
				mgsb_pkg::REG_START_X:     cfg_q.start_x     <= cfg_data[15:0];
				mgsb_pkg::REG_START_Y:     cfg_q.start_y     <= cfg_data[15:0];
				mgsb_pkg::REG_GLYPH_SIZE:  cfg_q.glyph_size  <= cfg_data[7:0];
				mgsb_pkg::REG_GLYPH_COUNT: cfg_q.glyph_count <= cfg_data[7:0];
				mgsb_pkg::REG_FG_COLOR:    cfg_q.fg_color    <= cfg_data[15:0];
				mgsb_pkg::REG_BG_COLOR:    cfg_q.bg_color    <= cfg_data[15:0];
				mgsb_pkg::REG_MODE_FLAGS:  cfg_q.mode_flags  <= cfg_data[1:0];
				mgsb_pkg::REG_BOX_EXTENT:  cfg_q.box_extent  <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/mgsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mgsb_ctrl
// Sequencer of the blitter: string restart, glyph start checks and the
// bit-by-bit walk through each accepted byte.
// ----------------------------------------------------------------------------
module mgsb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  mgsb_pkg::sts_t     sts,
	output mgsb_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_INIT_MUL,
		ST_INIT_SET,
		ST_IDLE,
		ST_WRAP,
		ST_CHECK,
		ST_STEP
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && sts.in_ready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_INIT_MUL: cmd.init_mul = 1'b1;
			ST_INIT_SET: cmd.init_set = 1'b1;
			ST_IDLE: begin
				cmd.flush = 1'b1;
				if (accept) begin
					priority if (sts.done) begin
						cmd.load = 1'b0;
					end else if (sts.exhausted) begin
						cmd.set_done = 1'b1;
					end else if (sts.first) begin
						cmd.load = 1'b1;
					end else if (sts.aborted) begin
						cmd.skip = 1'b1;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_WRAP:  cmd.wrap  = 1'b1;
			ST_CHECK: cmd.check = 1'b1;
			ST_STEP:  cmd.step  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_MUL;
		end else if (cfg_we) begin
			state_q <= ST_INIT_MUL;
		end else begin
			unique case (state_q)
				ST_INIT_MUL: state_q <= ST_INIT_SET;
				ST_INIT_SET: state_q <= ST_IDLE;
				ST_IDLE: begin
					if (accept && !sts.done && !sts.exhausted) begin
						priority if (sts.first) begin
							state_q <= ST_WRAP;
						end else if (!sts.aborted) begin
							state_q <= ST_STEP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WRAP:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= sts.check_fail ? ST_IDLE : ST_STEP;
				ST_STEP: begin
					if (sts.step_ready && sts.step_end) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/mgsb_dp.sv -----
// ----------------------------------------------------------------------------
// mgsb_dp
// Datapath of the blitter: pen and draw coordinates, glyph counters, the
// pending pixel and the output register.
// ----------------------------------------------------------------------------
module mgsb_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mgsb_pkg::cfg_t     cfg,
	input  mgsb_pkg::cmd_t     cmd,
	output mgsb_pkg::sts_t     sts,
	input  logic [7:0]         s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,
	output logic               m_tlast
);

	localparam int BW = mgsb_pkg::BIG_W;

	logic [15:0] pen_x_q, pen_y_q, lo_x_q, lo_y_q, draw_x_q, draw_y_q;
	logic [15:0] prod_q;
	logic [BW-1:0] bpg_q, big_q;
	logic [7:0]  gd_q;
	logic        abort_q, done_q;
	logic [7:0]  byte_q;
	logic [2:0]  idx_q;
	mgsb_pkg::pixel_t pend_q, out_q;
	logic        pend_v_q, out_v_q, out_last_q;

	logic [7:0]  g, cnt;
	logic [5:0]  ceil8;
	logic [13:0] bpg_full;
	logic [15:0] prod_full;
	logic        centre;
	logic [15:0] ox_c, oy_c, ox, oy;
	logic        init_done;
	logic signed [17:0] wrap_lim, check_lim;
	logic        wrap_hit, check_fail;
	logic        bit_on, emit;
	logic [15:0] dy1, dx1;
	logic [16:0] row_diff;
	logic        abort_row, col_end, abort_col, step_end;
	logic        out_free, step_ready, step_go, byte_end;
	logic [BW-1:0] big_nx;
	logic        glyph_end;
	logic [7:0]  gd_nx;
	logic        flush_go, push_go, out_load;

	assign g   = cfg.glyph_size;
	assign cnt = cfg.glyph_count;

	// restart arithmetic
	assign ceil8     = {1'b0, g[7:3]} + {5'b0, |g[2:0]};
	assign bpg_full  = {8'b0, ceil8} * {6'b0, g};
	assign prod_full = {8'b0, g} * {8'b0, cnt};
	assign centre    = cfg.mode_flags[1];
	assign ox_c      = cfg.start_x - {1'b0, prod_q[15:1]};
	assign oy_c      = cfg.start_y - {9'b0, g[7:1]};
	assign ox        = centre ? ox_c : cfg.start_x;
	assign oy        = centre ? oy_c : cfg.start_y;
	assign init_done = (centre && ((ox_c > mgsb_pkg::SCREEN_W) || (oy_c > mgsb_pkg::SCREEN_H)))
		|| (g == 8'd0) || (cnt == 8'd0);

	// glyph start: line wrap, then box height
	assign wrap_lim   = $signed({2'b0, lo_x_q}) + $signed({2'b0, cfg.box_extent[31:16]})
		- $signed({10'b0, g});
	assign check_lim  = $signed({2'b0, lo_y_q}) + $signed({2'b0, cfg.box_extent[15:0]})
		- $signed({10'b0, g});
	assign wrap_hit   = $signed({2'b0, pen_x_q}) > wrap_lim;
	assign check_fail = $signed({2'b0, pen_y_q}) > check_lim;

	// one bit of the current byte
	assign bit_on    = byte_q[7];
	assign emit      = bit_on || !cfg.mode_flags[0];
	assign dy1       = draw_y_q + 16'd1;
	assign dx1       = draw_x_q + 16'd1;
	assign row_diff  = {1'b0, dy1} - {1'b0, pen_y_q};
	assign abort_row = dy1 >= mgsb_pkg::SCREEN_H;
	assign col_end   = !abort_row && (row_diff == {9'b0, g});
	assign abort_col = col_end && (dx1 >= mgsb_pkg::SCREEN_W);
	assign step_end  = abort_row || col_end || (idx_q == 3'd7);

	assign out_free   = !out_v_q || m_tready;
	assign step_ready = !emit || !pend_v_q || out_free;
	assign step_go    = cmd.step && step_ready;
	assign byte_end   = (step_go && step_end) || cmd.skip;
	assign big_nx     = big_q + {{(BW-1){1'b0}}, 1'b1};
	assign glyph_end  = big_nx >= bpg_q;
	assign gd_nx      = gd_q + 8'd1;

	// the pending pixel leaves as last of its byte on a flush, as not last on a push
	assign flush_go = cmd.flush && pend_v_q && out_free;
	assign push_go  = step_go && emit;
	assign out_load = flush_go || (push_go && pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			done_q   <= 1'b1;
			big_q    <= '0;
			gd_q     <= 8'd0;
			abort_q  <= 1'b0;
			idx_q    <= 3'd0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (push_go) begin
				pend_v_q <= 1'b1;
			end else if (flush_go) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.load) begin
				idx_q <= 3'd0;
			end else if (step_go) begin
				idx_q <= idx_q + 3'd1;
			end
			if (cmd.init_set) begin
				done_q  <= init_done;
				big_q   <= '0;
				gd_q    <= 8'd0;
				abort_q <= 1'b0;
			end else begin
				if (cmd.set_done || (cmd.check && check_fail)) begin
					done_q <= 1'b1;
				end
				if (cmd.check && !check_fail) begin
					abort_q <= 1'b0;
				end
				if (step_go) begin
					abort_q <= abort_row || abort_col;
				end
				if (byte_end) begin
					if (glyph_end) begin
						big_q   <= '0;
						gd_q    <= gd_nx;
						abort_q <= 1'b0;
						if (gd_nx >= cnt) begin
							done_q <= 1'b1;
						end
					end else begin
						big_q <= big_nx;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_mul) begin
			prod_q <= prod_full;
			bpg_q  <= bpg_full[BW-1:0];
		end
		if (cmd.init_set) begin
			pen_x_q  <= ox;
			pen_y_q  <= oy;
			lo_x_q   <= ox;
			lo_y_q   <= oy;
			draw_x_q <= ox;
			draw_y_q <= oy;
		end
		if (cmd.wrap && wrap_hit) begin
			pen_y_q <= pen_y_q + {8'b0, g};
			pen_x_q <= lo_x_q;
		end
		if (cmd.check && !check_fail) begin
			draw_x_q <= pen_x_q;
			draw_y_q <= pen_y_q;
		end
		if (cmd.load) begin
			byte_q <= s_tdata;
		end
		if (step_go) begin
			draw_y_q <= col_end ? pen_y_q : dy1;
			if (col_end) begin
				draw_x_q <= dx1;
			end
			byte_q <= {byte_q[6:0], 1'b0};
		end
		if (byte_end && glyph_end) begin
			pen_x_q <= pen_x_q + {8'b0, g};
		end
		if (push_go) begin
			pend_q.x     <= draw_x_q;
			pend_q.y     <= draw_y_q;
			pend_q.color <= bit_on ? cfg.fg_color : cfg.bg_color;
		end
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= flush_go;
		end
	end

	assign sts.done       = done_q;
	assign sts.exhausted  = (gd_q >= cnt) || (g == 8'd0);
	assign sts.first      = (big_q == '0);
	assign sts.aborted    = abort_q;
	assign sts.check_fail = check_fail;
	assign sts.step_ready = step_ready;
	assign sts.step_end   = step_end;
	assign sts.in_ready   = !pend_v_q || out_free;

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- hw/rtl/mono_glyph_string_blitter.sv -----
// ----------------------------------------------------------------------------
// mono_glyph_string_blitter
// Expands a stream of 1-bpp square glyph bytes into pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//  - Program the eight registers through cfg_we/cfg_index/cfg_data while the
//    block is idle; every write restarts the string (origin, wrap box and
//    centring are recomputed, with s_tready held low).
//  - Feed glyph bytes on s_*, column-major, top to bottom, MSB topmost.
//    Bytes that arrive after the string is finished are taken and dropped.
//  - Each byte yields 0 to 8 pixel writes on m_*; m_tlast marks the final
//    write caused by that byte.
// Byte walk and output rate:
//  - A byte is taken while idle and then walked one bit per cycle while
//    the output can take writes; the first byte of a glyph first passes
//    the line wrap and box height checks. Writes leave at one per cycle
//    while m_tready is high, and no new byte is taken until the walk ends.
//  - Each write is held in a pending register until the next write or the
//    end of its byte settles its tlast, then moves to the output register,
//    so a byte's first write waits for its second write or its byte's end.
// Reset and stalls:
//  - arst_n restores the register defaults and runs the restart sequence.
//  - A stalled m_tready holds the output item; the bit walk then stalls at
//    the next write and s_tready stays low until the pending write drains.
// ----------------------------------------------------------------------------
module mono_glyph_string_blitter (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// glyph byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] bitmap_byte
	// pixel write output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color
	output logic        m_tlast    // last_of_byte
);

	mgsb_pkg::cfg_t cfg;
	mgsb_pkg::cmd_t cmd;
	mgsb_pkg::sts_t sts;

	// hold the register file
	mgsb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequence restart, glyph start checks and the bit walk
	mgsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// advance coordinates and counters, drive the output item
	mgsb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- verif/mono_glyph_string_blitter_tb.sv -----
// ----------------------------------------------------------------------------
// mono_glyph_string_blitter_tb
// Self-checking bench for the glyph string blitter. A behavioural predictor
// expands every accepted glyph byte into the pixel writes it should cause.
// A checker compares each write on the output stream, field by field,
// against the oldest one still due. Directed strings cover the corner cases;
// random strings then run under many register settings, with random idling
// on both streams.
// ----------------------------------------------------------------------------
module mono_glyph_string_blitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// mode_flags bit positions and the four settings they make
	localparam int TRANSP_BIT = 0;
	localparam int CENTRE_BIT = 1;
	localparam logic [1:0] MODE_OPAQUE         = 2'b00;
	localparam logic [1:0] MODE_TRANSP         = 2'b01;
	localparam logic [1:0] MODE_CENTRED        = 2'b10;
	localparam logic [1:0] MODE_CENTRED_TRANSP = 2'b11;

	// quiet time after the last due write: one full byte walk plus glyph checks
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BYTES = 340;
	// cap on the string bytes sent per random setup; large glyphs are cut short by the next setup
	localparam int STRING_CAP   = 48;

	typedef struct packed {
		logic             last;
		mgsb_pkg::pixel_t pix;
	} pixel_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	mgsb_pkg::reg_idx_t cfg_index = mgsb_pkg::REG_START_X;
	logic [31:0]        cfg_data = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;   // [7:0] bitmap_byte
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [47:0]        m_tdata;        // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color
	logic               m_tlast;        // last_of_byte

	mono_glyph_string_blitter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: live register values and the pen of the string
	// ------------------------------------------------------------------
	mgsb_pkg::cfg_t live_cfg;
	logic [15:0] pen_x, pen_y;      // origin of the current glyph
	logic [15:0] line_x, line_y;    // origin of the string, wrap target
	logic [15:0] dot_x, dot_y;      // next pixel inside the glyph
	int          byte_pos;          // byte index within the glyph
	int          glyph_pos;         // glyphs finished so far
	bit          glyph_cut;         // glyph ran off screen, swallow the rest
	bit          string_over;

	pixel_item_t pixel_writes_due[$];

	int  mismatches;
	int  writes_seen;
	int  bytes_sent;
	int  random_bytes;
	int  settings_loaded;
	int  cycle_count;
	int  rx_hold;
	bit  tx_calm;
	bit  rx_calm;

	// ------------------------------------------------------------------
	// Reporting and random idling
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		// print the first few, count them all
		if (mismatches < 20)
			$display("MISMATCH @%0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// mostly none or short, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// Restart the string from the live registers; any register write does this.
	function automatic void rewind_pen();
		logic [15:0] ox, oy;
		int g, n;
		g = int'(live_cfg.glyph_size);
		n = int'(live_cfg.glyph_count);
		ox = live_cfg.start_x;
		oy = live_cfg.start_y;
		string_over = 1'b0;
		if (live_cfg.mode_flags[CENTRE_BIT]) begin
			// centre on the start point; an origin off screen rejects the string
			ox = 16'(int'(live_cfg.start_x) - ((g * n) >> 1));
			oy = 16'(int'(live_cfg.start_y) - (g >> 1));
			if (ox > mgsb_pkg::SCREEN_W || oy > mgsb_pkg::SCREEN_H)
				string_over = 1'b1;
		end
		pen_x = ox;
		pen_y = oy;
		line_x = ox;
		line_y = oy;
		dot_x = ox;
		dot_y = oy;
		byte_pos = 0;
		glyph_pos = 0;
		glyph_cut = 1'b0;
		if (g == 0 || n == 0)
			string_over = 1'b1;
	endfunction

	// Expand one accepted glyph byte into the writes it causes. The last write
	// is held back until the walk ends, so that its tlast can be settled.
	task automatic expand_glyph_byte(input logic [7:0] bits);
		int g, span, bw, bh;
		bit hit, have_pend;
		pixel_item_t pend;
		g = int'(live_cfg.glyph_size);
		span = ((g >> 3) + (((g & 7) != 0) ? 1 : 0)) * g;
		have_pend = 1'b0;
		pend = '0;
		if (string_over)
			return;
		if (glyph_pos >= int'(live_cfg.glyph_count) || g == 0) begin
			string_over = 1'b1;
			return;
		end
		if (byte_pos == 0) begin
			// glyph start: wrap to the next line, then test the box height,
			// both in signed arithmetic without wrap
			bw = int'(live_cfg.box_extent[31:16]);
			bh = int'(live_cfg.box_extent[15:0]);
			if (int'(pen_x) > int'(line_x) + bw - g) begin
				pen_y = pen_y + 16'(g);
				pen_x = line_x;
			end
			if (int'(pen_y) > int'(line_y) + bh - g) begin
				string_over = 1'b1;
				return;
			end
			dot_x = pen_x;
			dot_y = pen_y;
			glyph_cut = 1'b0;
		end
		if (!glyph_cut) begin
			for (int i = 7; i >= 0; i--) begin
				hit = bits[i];
				if (hit || !live_cfg.mode_flags[TRANSP_BIT]) begin
					if (have_pend)
						pixel_writes_due.push_back(pend);
					pend.last = 1'b0;
					pend.pix.x = dot_x;
					pend.pix.y = dot_y;
					pend.pix.color = hit ? live_cfg.fg_color : live_cfg.bg_color;
					have_pend = 1'b1;
				end
				dot_y = dot_y + 16'd1;
				// bottom edge: abort after the write that reached it
				if (dot_y >= mgsb_pkg::SCREEN_H) begin
					glyph_cut = 1'b1;
					break;
				end
				// column complete: skip the pad bits, step right
				if (int'(dot_y) - int'(pen_y) == g) begin
					dot_y = pen_y;
					dot_x = dot_x + 16'd1;
					if (dot_x >= mgsb_pkg::SCREEN_W)
						glyph_cut = 1'b1;
					break;
				end
			end
			if (have_pend) begin
				pend.last = 1'b1;
				pixel_writes_due.push_back(pend);
			end
		end
		byte_pos++;
		if (byte_pos >= span) begin
			byte_pos = 0;
			glyph_cut = 1'b0;
			glyph_pos++;
			pen_x = pen_x + 16'(g);
			if (glyph_pos >= int'(live_cfg.glyph_count))
				string_over = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Offer one byte, hold it until taken, then predict and idle at random.
	// Valid is only lowered when a gap follows, so it never drops and rises
	// again in the same step.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		expand_glyph_byte(b);
		bytes_sent++;
		gap = tx_calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every due write, then let the last byte walk finish.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pixel_writes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] reg_value(input mgsb_pkg::cfg_t c,
			input mgsb_pkg::reg_idx_t idx);
		case (idx)
			mgsb_pkg::REG_START_X:     return {16'd0, c.start_x};
			mgsb_pkg::REG_START_Y:     return {16'd0, c.start_y};
			mgsb_pkg::REG_GLYPH_SIZE:  return {24'd0, c.glyph_size};
			mgsb_pkg::REG_GLYPH_COUNT: return {24'd0, c.glyph_count};
			mgsb_pkg::REG_FG_COLOR:    return {16'd0, c.fg_color};
			mgsb_pkg::REG_BG_COLOR:    return {16'd0, c.bg_color};
			mgsb_pkg::REG_MODE_FLAGS:  return {30'd0, c.mode_flags};
			default:                   return c.box_extent;
		endcase
	endfunction

	// Write all eight registers back to back while the block is idle.
	task automatic load_setup(input mgsb_pkg::cfg_t c);
		mgsb_pkg::reg_idx_t idx;
		drain_block();
		idx = idx.first();
		for (int k = 0; k < idx.num(); k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= reg_value(c, idx);
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		live_cfg = c;
		rewind_pen();
		settings_loaded++;
	endtask

	function automatic mgsb_pkg::cfg_t make_setup(input logic [15:0] sx,
			input logic [15:0] sy, input logic [7:0] size, input logic [7:0] count,
			input logic [15:0] fg, input logic [15:0] bg, input logic [1:0] mode,
			input logic [31:0] box);
		mgsb_pkg::cfg_t c;
		c.start_x = sx;
		c.start_y = sy;
		c.glyph_size = size;
		c.glyph_count = count;
		c.fg_color = fg;
		c.bg_color = bg;
		c.mode_flags = mode;
		c.box_extent = box;
		return c;
	endfunction

	// Mostly small glyphs placed on screen with a fitting wrap box; now and
	// then huge glyphs, edge positions, wild coordinates and odd boxes.
	function automatic mgsb_pkg::cfg_t random_setup();
		mgsb_pkg::cfg_t c;
		int r, g;
		r = $urandom_range(0, 99);
		if (r < 3)
			g = 0;
		else if (r < 70)
			g = $urandom_range(1, 10);
		else if (r < 92)
			g = $urandom_range(11, 24);
		else
			g = $urandom_range(200, 255);
		c.glyph_size = 8'(g);
		r = $urandom_range(0, 99);
		if (r < 5)
			c.glyph_count = 8'd0;
		else if (r < 12)
			c.glyph_count = 8'd255;
		else
			c.glyph_count = 8'($urandom_range(1, 4));
		r = $urandom_range(0, 9);
		if (r == 0) begin
			c.start_x = 16'($urandom);
			c.start_y = 16'($urandom);
		end else if (r == 1) begin
			c.start_x = 16'($urandom_range(465, 479));
			c.start_y = 16'($urandom_range(785, 799));
		end else begin
			c.start_x = 16'($urandom_range(0, 440));
			c.start_y = 16'($urandom_range(0, 760));
		end
		c.fg_color = 16'($urandom);
		c.bg_color = 16'($urandom);
		c.mode_flags = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		if (r == 0)
			c.box_extent = $urandom;
		else if (r == 1)
			c.box_extent = '0;
		else
			c.box_extent = {16'(g * $urandom_range(1, 4)), 16'(g * $urandom_range(1, 3))};
		return c;
	endfunction

	// half the bytes solid or empty, the rest random
	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset leaves glyph_count at zero: the string is over before it starts.
	task automatic test_reset_defaults();
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	// Two opaque glyphs of side three at the screen corner: one byte per
	// column, five pad bits dropped from each.
	task automatic test_opaque_glyphs();
		load_setup(make_setup(16'd0, 16'd0, 8'd3, 8'd2, 16'hFFFF, 16'h0000,
			MODE_OPAQUE, {16'd64, 16'd64}));
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'h81);
		send_byte(8'h7E);
	endtask

	// Transparent mode: an empty byte writes nothing, pad bits never write.
	task automatic test_transparent_pad();
		load_setup(make_setup(16'd100, 16'd200, 8'd3, 8'd1, 16'hF800, 16'h07E0,
			MODE_TRANSP, {16'd16, 16'd16}));
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h20);
	endtask

	// A box one glyph wide: the second glyph wraps down a line, the third
	// wraps below the box and ends the string.
	task automatic test_line_wrap_box();
		load_setup(make_setup(16'd10, 16'd20, 8'd2, 8'd3, 16'h1234, 16'hABCD,
			MODE_OPAQUE, {16'd2, 16'd4}));
		send_byte(8'hC0);
		send_byte(8'h40);
		send_byte(8'h80);
		send_byte(8'hC0);
		send_byte(8'hFF);
	endtask

	// Glyph starts two rows above the bottom: two writes, then the glyph
	// aborts and its remaining bytes are swallowed.
	task automatic test_screen_edge_abort();
		load_setup(make_setup(16'd5, 16'd798, 8'd4, 8'd1, 16'h0F0F, 16'hF0F0,
			MODE_OPAQUE, {16'd100, 16'd100}));
		send_byte(8'hF0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
	endtask

	// Centre mode: an accepted origin, then one that lands off screen.
	task automatic test_centre_mode();
		load_setup(make_setup(16'd100, 16'd100, 8'd2, 8'd1, 16'hAAAA, 16'h5555,
			MODE_CENTRED_TRANSP, {16'd8, 16'd8}));
		send_byte(8'hAA);
		send_byte(8'h55);
		load_setup(make_setup(16'd0, 16'd0, 8'd4, 8'd2, 16'hFFFF, 16'h0000,
			MODE_CENTRED, {16'd64, 16'd64}));
		send_byte(8'hFF);
	endtask

	// Every register at its top value, then every register at zero.
	task automatic test_extreme_settings();
		load_setup(make_setup(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
			MODE_CENTRED_TRANSP, 32'hFFFF_FFFF));
		send_byte(8'hFF);
		load_setup(make_setup(16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000,
			MODE_OPAQUE, 32'h0000_0000));
		send_byte(8'hFF);
	endtask

	// Random settings, each fed a well formed string (cut short for huge
	// glyphs) and a little trailing noise. Some settings run with no idling.
	task automatic test_random_strings();
		mgsb_pkg::cfg_t c;
		int g, total, burst;
		while (random_bytes < RANDOM_BYTES) begin
			c = random_setup();
			load_setup(c);
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			g = int'(c.glyph_size);
			total = ((g >> 3) + (((g & 7) != 0) ? 1 : 0)) * g * int'(c.glyph_count);
			burst = (total < STRING_CAP) ? total : STRING_CAP;
			burst += $urandom_range(0, 2);
			repeat (burst) begin
				send_byte(random_byte());
				random_bytes++;
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure and the write checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_calm) begin
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				rx_hold = idle_len();
		end
	end

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("write %0d %s got %h want %h",
				writes_seen, name, got, want));
	endtask

	always @(posedge clk) begin
		pixel_item_t      want;
		mgsb_pkg::pixel_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = mgsb_pkg::pixel_t'(m_tdata);
			if (pixel_writes_due.size() == 0) begin
				report_mismatch($sformatf("write %0d at (%0d,%0d) with none due",
					writes_seen, got.x, got.y));
			end else begin
				want = pixel_writes_due.pop_front();
				check_field("pixel_x", got.x, want.pix.x);
				check_field("pixel_y", got.y, want.pix.y);
				check_field("pixel_color", got.color, want.pix.color);
				check_field("last_of_byte", {15'd0, m_tlast}, {15'd0, want.last});
			end
			writes_seen++;
		end
	end

	// Hard stop if the handshakes ever hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d writes still due",
				cycle_count, pixel_writes_due.size());
			$display("mono_glyph_string_blitter verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		// mirror the reset register values in the predictor
		live_cfg = make_setup(16'd0, 16'd0, 8'd8, 8'd0, 16'hFFFF, 16'h0000,
			MODE_OPAQUE, 32'd0);
		rewind_pen();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_opaque_glyphs();
		test_transparent_pad();
		test_line_wrap_box();
		test_screen_edge_abort();
		test_centre_mode();
		test_extreme_settings();
		test_random_strings();

		drain_block();
		if (pixel_writes_due.size() != 0)
			report_mismatch($sformatf("%0d writes never arrived", pixel_writes_due.size()));

		$display("Sent %0d glyph bytes under %0d register settings, checked %0d pixel writes.",
			bytes_sent, settings_loaded, writes_seen);
		$display("Covered opaque, transparent and centred strings, line wrap, box cut-off, ",
			"screen-edge aborts and ignored trailing bytes.");
		if (mismatches == 0) begin
			$display("mono_glyph_string_blitter verification clean");
		end else begin
			$display("mono_glyph_string_blitter verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/mgsb_pkg.sv
hw/rtl/mgsb_regs.sv
hw/rtl/mgsb_ctrl.sv
hw/rtl/mgsb_dp.sv
hw/rtl/mono_glyph_string_blitter.sv
verif/mono_glyph_string_blitter_tb.sv
